FILE: design/irc_tok_pkg.sv
// Shared types and constants of the IRC line tokenizer.
// No dependencies; compile first.
package irc_tok_pkg;

	// Width of the field index carried on each result beat
	localparam int FIELD_INDEX_BITS = 6;

	typedef logic [FIELD_INDEX_BITS-1:0] field_idx_t;
	typedef logic [7:0]                  byte_t;
	typedef logic [1:0]                  kind_t;

	localparam field_idx_t IDX_MAX = {FIELD_INDEX_BITS{1'b1}};

	// Result beat kinds
	localparam kind_t KIND_DATA      = 2'd0;
	localparam kind_t KIND_FIELD_END = 2'd1;
	localparam kind_t KIND_CMD_END   = 2'd2;

	// Bytes with a meaning to the parser
	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_LF    = 8'h0A;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_COLON = 8'h3A;

endpackage

FILE: design/irc_tok_in_if.sv
// Valid/ready channel carrying raw stream bytes into the tokenizer.
// Depends on irc_tok_pkg.
interface irc_tok_in_if
	import irc_tok_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

FILE: design/irc_tok_out_if.sv
// Valid/ready channel carrying token beats out of the tokenizer.
// Depends on irc_tok_pkg.
interface irc_tok_out_if
	import irc_tok_pkg::*;
();
	logic       valid;
	logic       ready;
	kind_t      out_kind;
	byte_t      out_byte;
	field_idx_t field_index;
	logic       index_saturated;

	modport source (output valid, output out_kind, output out_byte, output field_index,
		output index_saturated, input ready);
	modport sink (input valid, input out_kind, input out_byte, input field_index,
		input index_saturated, output ready);
endinterface

FILE: design/irc_line_tokenizer.sv
// IRC line tokenizer: one raw byte in per beat, at most one token beat out.
// Depends on irc_tok_pkg, irc_tok_in_if and irc_tok_out_if.
//
// The block takes one byte per clock, sustained while tok is not stalled, on the
// raw channel and turns it into data, field-end and command-end beats on the tok
// channel. A byte is held in an input register, parsed against the line state
// (phase, field count, overflow flag) and its beat (if any) lands in the output
// register, from which it is shown on tok. The raw side keeps accepting while a
// result waits, as long as the output register empties in the same cycle; the
// limit of one byte per clock is the single parse step on the line state.
// CR/LF end a line, NUL bytes produce nothing, a leading ':' prefix and leading
// spaces are skipped, and a ':' after a field separator opens the trailing field.
module irc_line_tokenizer
	import irc_tok_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	irc_tok_in_if.sink    raw,
	irc_tok_out_if.source tok
);

	// Parse phases
	localparam logic [2:0] PH_LINE_START  = 3'd0;
	localparam logic [2:0] PH_PREFIX      = 3'd1;
	localparam logic [2:0] PH_LEAD        = 3'd2;
	localparam logic [2:0] PH_FIELD       = 3'd3;
	localparam logic [2:0] PH_AFTER_SPACE = 3'd4;
	localparam logic [2:0] PH_TRAIL       = 3'd5;

	logic       raw_valid_s1;
	byte_t      raw_byte_s1;

	logic       out_valid_s2;
	kind_t      out_kind_s2;
	byte_t      out_byte_s2;
	field_idx_t out_idx_s2;
	logic       out_sat_s2;

	logic [2:0] phase_q, phase_nxt;
	field_idx_t field_cnt_q, field_cnt_nxt;
	logic       ovf_q, ovf_nxt;

	logic       advance;
	logic       emit;
	kind_t      emit_kind;
	byte_t      emit_byte;
	field_idx_t emit_idx;
	logic       emit_sat;
	logic       is_eol;

	// Output register empties or is free: the parse step may run
	assign advance   = !out_valid_s2 || tok.ready;
	assign raw.ready = !raw_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			raw_valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.ready && raw.valid) begin
			raw_byte_s1 <= raw.in_byte;
		end
	end

	assign is_eol = (raw_byte_s1 == CH_CR) || (raw_byte_s1 == CH_LF);

	// Parse step on the held byte
	always_comb begin
		phase_nxt     = phase_q;
		field_cnt_nxt = field_cnt_q;
		ovf_nxt       = ovf_q;
		emit          = 1'b0;
		emit_kind     = KIND_DATA;
		emit_byte     = '0;
		emit_idx      = field_cnt_q;
		emit_sat      = ovf_q;

		if (raw_byte_s1 == CH_NUL) begin
			// dropped, state untouched
		end else if (is_eol) begin
			if (phase_q inside {PH_FIELD, PH_AFTER_SPACE, PH_TRAIL}) begin
				emit      = 1'b1;
				emit_kind = KIND_CMD_END;
			end
			phase_nxt     = PH_LINE_START;
			field_cnt_nxt = '0;
			ovf_nxt       = 1'b0;
		end else begin
			unique case (phase_q)
				PH_LINE_START: begin
					if (raw_byte_s1 == CH_COLON) begin
						phase_nxt = PH_PREFIX;
					end else if (raw_byte_s1 == CH_SPACE) begin
						phase_nxt = PH_LEAD;
					end else begin
						phase_nxt = PH_FIELD;
						emit      = 1'b1;
						emit_byte = raw_byte_s1;
					end
				end
				PH_PREFIX: begin
					if (raw_byte_s1 == CH_SPACE) begin
						phase_nxt = PH_LEAD;
					end
				end
				PH_LEAD: begin
					if (raw_byte_s1 != CH_SPACE) begin
						phase_nxt = PH_FIELD;
						emit      = 1'b1;
						emit_byte = raw_byte_s1;
					end
				end
				PH_FIELD, PH_AFTER_SPACE: begin
					if (raw_byte_s1 == CH_SPACE) begin
						// close the field; end beat carries the old index, new flag
						if (field_cnt_q == IDX_MAX) begin
							ovf_nxt = 1'b1;
						end else begin
							field_cnt_nxt = field_cnt_q + 1'b1;
						end
						phase_nxt = PH_AFTER_SPACE;
						emit      = 1'b1;
						emit_kind = KIND_FIELD_END;
						emit_sat  = ovf_nxt;
					end else if (phase_q == PH_AFTER_SPACE && raw_byte_s1 == CH_COLON) begin
						phase_nxt = PH_TRAIL;
					end else begin
						phase_nxt = PH_FIELD;
						emit      = 1'b1;
						emit_byte = raw_byte_s1;
					end
				end
				PH_TRAIL: begin
					emit      = 1'b1;
					emit_byte = raw_byte_s1;
				end
				default: begin
					// unused codes recover to line start
					phase_nxt     = PH_LINE_START;
					field_cnt_nxt = '0;
					ovf_nxt       = 1'b0;
				end
			endcase
		end
	end

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LINE_START;
			field_cnt_q <= '0;
			ovf_q       <= 1'b0;
		end else if (raw_valid_s1 && advance) begin
			phase_q     <= phase_nxt;
			field_cnt_q <= field_cnt_nxt;
			ovf_q       <= ovf_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= raw_valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && raw_valid_s1 && emit) begin
			out_kind_s2 <= emit_kind;
			out_byte_s2 <= emit_byte;
			out_idx_s2  <= emit_idx;
			out_sat_s2  <= emit_sat;
		end
	end

	assign tok.valid           = out_valid_s2;
	assign tok.out_kind        = out_kind_s2;
	assign tok.out_byte        = out_byte_s2;
	assign tok.field_index     = out_idx_s2;
	assign tok.index_saturated = out_sat_s2;

endmodule

FILE: design/irc_tok_checker.sv
// Port-level checks for the IRC line tokenizer, bound into irc_line_tokenizer.
// Depends on irc_tok_pkg and irc_line_tokenizer.
module irc_tok_checker
	import irc_tok_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       tok_valid,
	input logic       tok_ready,
	input kind_t      tok_kind,
	input byte_t      tok_byte,
	input field_idx_t tok_idx,
	input logic       tok_sat
);

	// Kind code 3 is never produced
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_kind == KIND_DATA || tok_kind == KIND_FIELD_END ||
			tok_kind == KIND_CMD_END))
		else $error("token beat with undefined kind");

	// Only data beats carry a byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_kind != KIND_DATA |-> tok_byte == '0)
		else $error("non-data beat with nonzero byte");

	// Saturation only ever shows with the index pinned at the top
	a_sat_top: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_sat |-> tok_idx == IDX_MAX)
		else $error("saturated beat below top index");

	// A stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) && $stable(tok_byte)
			&& $stable(tok_idx) && $stable(tok_sat))
		else $error("stalled token beat changed");

endmodule

bind irc_line_tokenizer irc_tok_checker u_irc_tok_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok.valid),
	.tok_ready (tok.ready),
	.tok_kind  (tok.out_kind),
	.tok_byte  (tok.out_byte),
	.tok_idx   (tok.field_index),
	.tok_sat   (tok.index_saturated)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for irc_line_tokenizer: random byte streams, a line parser
// predictor and an in-order token check. Needs irc_tok_pkg and both channel interfaces.
module tb;
	import irc_tok_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL  = 300;
	localparam int PHASE_ITEMS = 340;

	typedef enum logic [2:0] {
		PH_LINE_START, PH_PREFIX, PH_LEAD, PH_FIELD, PH_AFTER_SPACE, PH_TRAIL
	} parse_phase_e;

	typedef struct packed {
		kind_t      kind;
		byte_t      data;
		field_idx_t idx;
		logic       sat;
	} token_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic  src_valid = 1'b0;
	byte_t src_byte  = '0;
	logic  snk_ready = 1'b0;
	logic  raw_fire  = 1'b0;

	irc_tok_in_if  raw_if ();
	irc_tok_out_if tok_if ();

	assign raw_if.valid   = src_valid;
	assign raw_if.in_byte = src_byte;
	assign tok_if.ready   = snk_ready;

	irc_line_tokenizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_if),
		.tok    (tok_if)
	);

	// Bytes waiting to be sent, and tokens predicted but not yet seen
	byte_t  stream_bytes[$];
	token_t expected_tokens[$];

	int items_queued   = 0;
	int items_accepted = 0;
	int errors         = 0;
	int cycle_count    = 0;
	int src_idle_pct   = 0;
	int snk_stall_pct  = 0;
	int stall_req      = 0;
	int stall_ack      = 0;
	int stall_left     = 0;
	bit nul_inject     = 1'b0;

	// Predictor line state
	parse_phase_e line_phase  = PH_LINE_START;
	field_idx_t   field_count = '0;
	logic         field_ovf   = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advance the line parser by one byte; returns 1 when a token comes out
	function automatic bit tokenize_byte(input byte_t b, output token_t t);
		field_idx_t closed;
		bit         hit;
		hit = 1'b0;
		t   = '0;
		if (b == CH_NUL) begin
			hit = 1'b0;
		end else if (b == CH_CR || b == CH_LF) begin
			hit = (line_phase == PH_FIELD || line_phase == PH_AFTER_SPACE ||
				line_phase == PH_TRAIL);
			t = '{KIND_CMD_END, CH_NUL, field_count, field_ovf};
			line_phase  = PH_LINE_START;
			field_count = '0;
			field_ovf   = 1'b0;
		end else begin
			case (line_phase)
				PH_LINE_START: begin
					if (b == CH_COLON) begin
						line_phase = PH_PREFIX;
					end else if (b == CH_SPACE) begin
						line_phase = PH_LEAD;
					end else begin
						line_phase = PH_FIELD;
						hit = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (b == CH_SPACE) line_phase = PH_LEAD;
				end
				PH_LEAD: begin
					if (b != CH_SPACE) begin
						line_phase = PH_FIELD;
						hit = 1'b1;
					end
				end
				PH_AFTER_SPACE: begin
					if (b == CH_COLON) begin
						line_phase = PH_TRAIL;
					end else if (b != CH_SPACE) begin
						line_phase = PH_FIELD;
						hit = 1'b1;
					end
				end
				default: hit = 1'b1;
			endcase
			if (hit) t = '{KIND_DATA, b, field_count, field_ovf};
			// space in a field or after a separator closes the field
			if (b == CH_SPACE && (line_phase == PH_FIELD || line_phase == PH_AFTER_SPACE)) begin
				closed = field_count;
				if (field_count == IDX_MAX) field_ovf = 1'b1;
				else field_count = field_count + 1'b1;
				t = '{KIND_FIELD_END, CH_NUL, closed, field_ovf};
				line_phase = PH_AFTER_SPACE;
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	task automatic put(input byte_t b);
		if (nul_inject && $urandom_range(59) == 0) begin
			stream_bytes.push_back(CH_NUL);
			items_queued++;
		end
		stream_bytes.push_back(b);
		items_queued++;
	endtask

	// A word of len characters, each never a separator, line end or NUL
	task automatic put_word(input int len);
		int r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(19);
			if (r == 0) put(CH_COLON);
			else if (r == 1) put(byte_t'($urandom_range(128, 255)));
			else put(byte_t'($urandom_range(33, 126)));
		end
	endtask

	task automatic put_eol();
		case ($urandom_range(3))
			0: put(CH_LF);
			1: put(CH_CR);
			2: begin
				put(CH_CR);
				put(CH_LF);
			end
			default: begin
				put(CH_CR);
				put(CH_LF);
				put(CH_CR);
				put(CH_LF);
			end
		endcase
	endtask

	// Mostly well-formed lines with random content, some noise and broken lines
	task automatic gen_line();
		int  pick;
		int  nparams;
		bit  long_line;
		pick = $urandom_range(19);
		if (pick < 3) begin
			for (int i = $urandom_range(1, 10); i > 0; i--)
				put(byte_t'($urandom_range(0, 255)));
		end else if (pick < 5) begin
			case ($urandom_range(2))
				0: begin
					put(CH_COLON);
					put_word($urandom_range(0, 8));
				end
				1: for (int i = $urandom_range(1, 4); i > 0; i--) put(CH_SPACE);
				default: begin
					put(CH_COLON);
					put_word($urandom_range(1, 5));
					for (int i = $urandom_range(1, 3); i > 0; i--) put(CH_SPACE);
				end
			endcase
		end else begin
			if ($urandom_range(2) == 0) begin
				put(CH_COLON);
				put_word($urandom_range(1, 8));
				put(CH_SPACE);
			end
			if ($urandom_range(3) == 0)
				for (int i = $urandom_range(1, 3); i > 0; i--) put(CH_SPACE);
			put_word($urandom_range(1, 6));
			long_line = ($urandom_range(10) == 0);
			nparams   = long_line ? $urandom_range(60, 70) : $urandom_range(0, 5);
			for (int i = 0; i < nparams; i++) begin
				put(CH_SPACE);
				if ($urandom_range(5) == 0) put(CH_SPACE);
				put_word(long_line ? $urandom_range(0, 1) : $urandom_range(0, 6));
			end
			if ($urandom_range(1) == 0) begin
				put(CH_SPACE);
				put(CH_COLON);
				for (int i = $urandom_range(0, 10); i > 0; i--) begin
					if ($urandom_range(4) == 0) put(CH_SPACE);
					else put_word(1);
				end
			end
		end
		put_eol();
	endtask

	// Wait until every byte is taken and every token has come out
	task automatic drain();
		@(negedge clk);
		while (items_accepted != items_queued || expected_tokens.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_random(input int src_pct, input int snk_pct, input bit long_hold);
		int target;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		target = items_queued + PHASE_ITEMS;
		while (items_queued < target) gen_line();
		if (long_hold) stall_req++;
		drain();
	endtask

	// Byte driver: new beat at the falling edge once the previous one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (!src_valid || raw_fire) begin
			if (stream_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				src_valid <= 1'b1;
				src_byte  <= stream_bytes.pop_front();
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Token sink: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			snk_ready <= 1'b0;
		end else if (stall_ack != stall_req) begin
			stall_ack  = stall_req;
			stall_left = LONG_STALL;
			snk_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			snk_ready <= 1'b0;
		end else begin
			snk_ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Monitor: predict on each accepted byte, check each accepted token
	always @(posedge clk) begin
		token_t want;
		token_t got;
		if (arst_n) begin
			raw_fire <= raw_if.valid && raw_if.ready;
			if (raw_if.valid && raw_if.ready) begin
				items_accepted++;
				if (tokenize_byte(raw_if.in_byte, want)) expected_tokens.push_back(want);
			end
			if (tok_if.valid && tok_if.ready) begin
				got = '{tok_if.out_kind, tok_if.out_byte, tok_if.field_index,
					tok_if.index_saturated};
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected token kind %0d byte %h idx %0d sat %0d",
						$time, got.kind, got.data, got.idx, got.sat);
					errors++;
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want) begin
						$display("%0t: token mismatch: expected kind %0d byte %h idx %0d sat %0d",
							$time, want.kind, want.data, want.idx, want.sat);
						$display("%0t:                 actual   kind %0d byte %h idx %0d sat %0d",
							$time, got.kind, got.data, got.idx, got.sat);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[irc_line_tokenizer] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty lines, prefix, leading spaces, colon not first,
		// empty fields, trailing field, byte extremes, NUL, lines without command
		put(CH_CR);
		put(CH_LF);
		put(CH_COLON);
		put("p");
		put(CH_SPACE);
		put("A");
		put(CH_CR);
		put(CH_SPACE);
		put(CH_SPACE);
		put(CH_COLON);
		put("B");
		put(CH_SPACE);
		put(CH_SPACE);
		put(CH_COLON);
		put("t");
		put(CH_SPACE);
		put("x");
		put(CH_LF);
		put(8'hFF);
		put(CH_NUL);
		put(8'h01);
		put(8'h7F);
		put(CH_LF);
		put(CH_COLON);
		put(CH_LF);
		put(CH_SPACE);
		put(CH_CR);
		drain();

		nul_inject = 1'b1;
		run_random(0, 0, 1'b0);
		run_random(46, 0, 1'b0);
		run_random(0, 46, 1'b0);
		run_random(14, 14, 1'b0);
		run_random(0, 0, 1'b1);

		repeat (8) @(negedge clk);
		if (expected_tokens.size() != 0) begin
			$display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
			errors++;
		end
		if (errors == 0)
			$display("[irc_line_tokenizer] OK");
		else
			$display("[irc_line_tokenizer] ERROR");
		$finish;
	end

endmodule
